### design/bmr_pkg.sv
// ----------------------------------------------------------------------------
// bmr_pkg
// Shared types, constants and the step microprogram of the bicycle model
// rollout.
// ----------------------------------------------------------------------------
package bmr_pkg;

  localparam int HORIZON_DEF      = 20;
  localparam int CORDIC_ITERS_DEF = 24;

  localparam int NCFG   = 7;
  localparam int NIN    = 7;
  localparam int NSTATE = 5;
  localparam int NREGS  = 32;
  localparam int RAW    = 5;
  localparam int DW     = 64;

  // configuration register indexes
  localparam logic [2:0] CFG_FRONT = 3'd0;
  localparam logic [2:0] CFG_REAR  = 3'd1;
  localparam logic [2:0] CFG_MASS  = 3'd2;
  localparam logic [2:0] CFG_LF    = 3'd3;
  localparam logic [2:0] CFG_LR    = 3'd4;
  localparam logic [2:0] CFG_IZ    = 3'd5;
  localparam logic [2:0] CFG_DT    = 3'd6;

  // working register file slots
  localparam logic [4:0] R_B     = 5'd0;
  localparam logic [4:0] R_H     = 5'd1;
  localparam logic [4:0] R_R     = 5'd2;
  localparam logic [4:0] R_X     = 5'd3;
  localparam logic [4:0] R_Y     = 5'd4;
  localparam logic [4:0] R_STEER = 5'd5;
  localparam logic [4:0] R_V     = 5'd6;
  localparam logic [4:0] R_KCF   = 5'd7;
  localparam logic [4:0] R_KCR   = 5'd8;
  localparam logic [4:0] R_MASS  = 5'd9;
  localparam logic [4:0] R_LF    = 5'd10;
  localparam logic [4:0] R_LR    = 5'd11;
  localparam logic [4:0] R_IZ    = 5'd12;
  localparam logic [4:0] R_DT    = 5'd13;
  localparam logic [4:0] R_KCFL  = 5'd14;
  localparam logic [4:0] R_KCRL  = 5'd15;
  localparam logic [4:0] R_ZERO  = 5'd16;
  localparam logic [4:0] R_T0    = 5'd17;
  localparam logic [4:0] R_T1    = 5'd18;
  localparam logic [4:0] R_EF    = 5'd19;
  localparam logic [4:0] R_ER    = 5'd20;
  localparam logic [4:0] R_FR    = 5'd21;
  localparam logic [4:0] R_DB    = 5'd22;
  localparam logic [4:0] R_DR    = 5'd23;
  localparam logic [4:0] R_SB    = 5'd24;
  localparam logic [4:0] R_CB    = 5'd25;
  localparam logic [4:0] R_SH    = 5'd26;
  localparam logic [4:0] R_CH    = 5'd27;
  localparam logic [4:0] R_VT    = 5'd28;
  localparam logic [4:0] R_DX    = 5'd29;
  localparam logic [4:0] R_DY    = 5'd30;

  localparam logic [5:0] STEP_START = 6'd2;
  localparam logic [5:0] LAST_PC    = 6'd42;

  localparam logic [63:0] SMAX  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NSMAX = 64'h8000_0000_0000_0001;

  localparam logic [35:0] Q30_PI      = 36'd3373259426;
  localparam logic [35:0] Q30_TWO_PI  = 36'd6746518852;
  localparam logic [35:0] Q30_HALF_PI = 36'd1686629713;
  localparam logic [35:0] Q30_GAIN    = 36'd652032874;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_SATADD,
    OP_MUL,
    OP_DIV,
    OP_SINCOS
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [4:0] dst;
    logic [4:0] a;
    logic [4:0] b;
  } uop_t;

  typedef struct packed {
    logic       capture;
    logic       ld_we;
    logic [4:0] ld_idx;
    logic [4:0] rd_a;
    logic [4:0] rd_b;
    logic       start;
    op_e        op;
    logic       wr0;
    logic       wr1;
    logic [4:0] wr_addr;
    logic       emit;
    logic [6:0] step;
    logic       bad;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic unit_done;
    logic speed_bad;
    logic out_free;
  } sts_t;

  function automatic logic [31:0] cfg_reset(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      CFG_MASS: v = 32'd65536;
      CFG_IZ:   v = 32'd65536;
      CFG_DT:   v = 32'd6554;
      default:  v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic uop_t mk(input op_e op, input logic [4:0] dst, input logic [4:0] a,
                              input logic [4:0] b);
    uop_t u;
    u.op = op; u.dst = dst; u.a = a; u.b = b;
    return u;
  endfunction

  // setup at 0..1, one Euler step from STEP_START to LAST_PC
  function automatic uop_t ucode(input logic [5:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = mk(OP_MUL,    R_KCFL, R_KCF,   R_LF);
      6'd1:  u = mk(OP_MUL,    R_KCRL, R_KCR,   R_LR);
      6'd2:  u = mk(OP_MUL,    R_T0,   R_LF,    R_R);
      6'd3:  u = mk(OP_DIV,    R_T0,   R_T0,    R_V);
      6'd4:  u = mk(OP_SUB,    R_T1,   R_STEER, R_B);
      6'd5:  u = mk(OP_SUB,    R_EF,   R_T1,    R_T0);
      6'd6:  u = mk(OP_MUL,    R_T0,   R_LR,    R_R);
      6'd7:  u = mk(OP_DIV,    R_T0,   R_T0,    R_V);
      6'd8:  u = mk(OP_SUB,    R_T1,   R_ZERO,  R_B);
      6'd9:  u = mk(OP_ADD,    R_ER,   R_T1,    R_T0);
      6'd10: u = mk(OP_MUL,    R_T0,   R_KCF,   R_EF);
      6'd11: u = mk(OP_DIV,    R_T0,   R_T0,    R_MASS);
      6'd12: u = mk(OP_DIV,    R_FR,   R_T0,    R_V);
      6'd13: u = mk(OP_MUL,    R_T0,   R_KCR,   R_ER);
      6'd14: u = mk(OP_DIV,    R_T0,   R_T0,    R_MASS);
      6'd15: u = mk(OP_DIV,    R_T0,   R_T0,    R_V);
      6'd16: u = mk(OP_ADD,    R_T1,   R_FR,    R_T0);
      6'd17: u = mk(OP_SUB,    R_DB,   R_T1,    R_R);
      6'd18: u = mk(OP_MUL,    R_T0,   R_KCFL,  R_EF);
      6'd19: u = mk(OP_DIV,    R_T0,   R_T0,    R_IZ);
      6'd20: u = mk(OP_MUL,    R_T1,   R_KCRL,  R_ER);
      6'd21: u = mk(OP_DIV,    R_T1,   R_T1,    R_IZ);
      6'd22: u = mk(OP_SUB,    R_DR,   R_T0,    R_T1);
      6'd23: u = mk(OP_SINCOS, R_SB,   R_B,     R_B);
      6'd24: u = mk(OP_SINCOS, R_SH,   R_H,     R_H);
      6'd25: u = mk(OP_DIV,    R_T0,   R_SB,    R_CB);
      6'd26: u = mk(OP_MUL,    R_VT,   R_V,     R_T0);
      6'd27: u = mk(OP_MUL,    R_T0,   R_V,     R_CH);
      6'd28: u = mk(OP_MUL,    R_T1,   R_VT,    R_SH);
      6'd29: u = mk(OP_SUB,    R_DX,   R_T0,    R_T1);
      6'd30: u = mk(OP_MUL,    R_T0,   R_V,     R_SH);
      6'd31: u = mk(OP_MUL,    R_T1,   R_VT,    R_CH);
      6'd32: u = mk(OP_ADD,    R_DY,   R_T0,    R_T1);
      6'd33: u = mk(OP_MUL,    R_T0,   R_DB,    R_DT);
      6'd34: u = mk(OP_SATADD, R_B,    R_B,     R_T0);
      6'd35: u = mk(OP_MUL,    R_T0,   R_R,     R_DT);
      6'd36: u = mk(OP_SATADD, R_H,    R_H,     R_T0);
      6'd37: u = mk(OP_MUL,    R_T0,   R_DR,    R_DT);
      6'd38: u = mk(OP_SATADD, R_R,    R_R,     R_T0);
      6'd39: u = mk(OP_MUL,    R_T0,   R_DX,    R_DT);
      6'd40: u = mk(OP_SATADD, R_X,    R_X,     R_T0);
      6'd41: u = mk(OP_MUL,    R_T0,   R_DY,    R_DT);
      6'd42: u = mk(OP_SATADD, R_Y,    R_Y,     R_T0);
      default: u = mk(OP_ADD, R_T1, R_ZERO, R_ZERO);
    endcase
    return u;
  endfunction

  function automatic logic [35:0] cordic_atan(input logic [4:0] i);
    logic [35:0] t;
    case (i)
      5'd0:  t = 36'd843314857;
      5'd1:  t = 36'd497837829;
      5'd2:  t = 36'd263043837;
      5'd3:  t = 36'd133525159;
      5'd4:  t = 36'd67021687;
      5'd5:  t = 36'd33543516;
      5'd6:  t = 36'd16775851;
      5'd7:  t = 36'd8388437;
      5'd8:  t = 36'd4194283;
      5'd9:  t = 36'd2097149;
      5'd10: t = 36'd1048576;
      5'd31: t = 36'd0;
      default: t = 36'd1 << (5'd30 - i);
    endcase
    return t;
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  // clamp a 65-bit sum to +-SMAX
  function automatic logic [63:0] sat_add(input logic [64:0] s);
    logic [63:0] r;
    if (!s[64] && s[63]) r = SMAX;
    else if (s[64] && (!s[63] || s[62:0] == 63'd0)) r = NSMAX;
    else r = s[63:0];
    return r;
  endfunction

  function automatic logic [63:0] sat32x(input logic [63:0] v);
    logic [63:0] r;
    if (!v[63] && v[62:31] != 32'd0) r = 64'h0000_0000_7FFF_FFFF;
    else if (v[63] && v[62:31] != 32'hFFFF_FFFF) r = 64'hFFFF_FFFF_8000_0000;
    else r = v;
    return r;
  endfunction

  function automatic logic [63:0] signed_of(input logic [63:0] m, input logic neg);
    logic [63:0] c;
    c = m[63] ? SMAX : m;
    return neg ? (~c + 64'd1) : c;
  endfunction

endpackage

### design/bmr_ram.sv
// ----------------------------------------------------------------------------
// bmr_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module bmr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

### design/bmr_dp.sv
// ----------------------------------------------------------------------------
// bmr_dp
// Datapath: configuration and input registers, working register file,
// sequential multiplier, bit-serial divider, CORDIC unit and output register.
// ----------------------------------------------------------------------------
module bmr_dp #(
  parameter int CORDIC_ITERS = bmr_pkg::CORDIC_ITERS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i,
  input  logic [223:0]  in_data_i,
  input  bmr_pkg::cmd_t cmd_i,
  output bmr_pkg::sts_t sts_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  output logic [231:0]  out_data_o,
  output logic          out_bad_o,
  output logic          out_last_o
);
  import bmr_pkg::*;

  localparam int IW = $clog2(CORDIC_ITERS);

  typedef enum logic [2:0] {U_IDLE, U_MUL, U_MFIN, U_DIV, U_RED, U_ROT} unit_e;

  logic [31:0] cfg_q [NCFG];
  logic [31:0] in_q  [NIN];
  logic [31:0] st_q  [NSTATE];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCFG; i++) cfg_q[i] <= cfg_reset(3'(i));
    end else if (cfg_we_i && cfg_index_i < 3'(NCFG)) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end

  // ---- register file ----
  logic        rf_we;
  logic [4:0]  rf_waddr;
  logic [63:0] rf_wdata, rd_a, rd_b, ld_val;
  logic [63:0] res0_q, res1_q;
  op_e         op_q;

  always_comb begin
    ld_val = 64'd0;
    if (cmd_i.ld_idx < 5'(NIN)) begin
      ld_val = {{32{in_q[cmd_i.ld_idx[2:0]][31]}}, in_q[cmd_i.ld_idx[2:0]]};
    end else begin
      case (cmd_i.ld_idx)
        R_KCF:   ld_val = {15'd0, cfg_q[CFG_FRONT], 17'd0};
        R_KCR:   ld_val = {15'd0, cfg_q[CFG_REAR], 17'd0};
        R_MASS:  ld_val = {32'd0, cfg_q[CFG_MASS]};
        R_LF:    ld_val = {32'd0, cfg_q[CFG_LF]};
        R_LR:    ld_val = {32'd0, cfg_q[CFG_LR]};
        R_IZ:    ld_val = {32'd0, cfg_q[CFG_IZ]};
        R_DT:    ld_val = {32'd0, cfg_q[CFG_DT]};
        default: ld_val = 64'd0;
      endcase
    end
    rf_we    = cmd_i.ld_we | cmd_i.wr0 | cmd_i.wr1;
    rf_waddr = cmd_i.ld_we ? cmd_i.ld_idx : cmd_i.wr_addr;
    rf_wdata = cmd_i.ld_we ? ld_val : (cmd_i.wr0 ? res0_q : res1_q);
  end

  bmr_ram #(.WIDTH(DW), .DEPTH(NREGS)) u_rf (
    .clk_i     (clk_i),
    .we_i      (rf_we),
    .waddr_i   (rf_waddr),
    .wdata_i   (rf_wdata),
    .raddr_a_i (cmd_i.rd_a),
    .raddr_b_i (cmd_i.rd_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // ---- input and running state registers ----
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      for (int i = 0; i < NIN; i++) in_q[i] <= in_data_i[32*i +: 32];
      for (int i = 0; i < NSTATE; i++) st_q[i] <= in_data_i[32*i +: 32];
    end else if (cmd_i.wr0 && op_q == OP_SATADD && cmd_i.wr_addr < 5'(NSTATE)) begin
      st_q[cmd_i.wr_addr[2:0]] <= res0_q[31:0];
    end
  end

  // ---- arithmetic units ----
  unit_e          ust_q;
  logic           done_q, neg_q, ov_q, aneg_q, cneg_q;
  logic [63:0]    ua_q, ub_q, quo_q;
  logic [127:0]   acc_q;
  logic [1:0]     mcnt_q;
  logic [79:0]    dvd_q;
  logic [64:0]    rem_q;
  logic [6:0]     dcnt_q;
  logic [45:0]    rm_q;
  logic [3:0]     rk_q;
  logic signed [35:0] cx_q, cy_q, cz_q;
  logic [IW-1:0]  ci_q;

  logic [63:0]  sa, sb, pa, pmag, mm;
  logic [31:0]  mx, my;
  logic [63:0]  mp;
  logic [127:0] addend;
  logic [64:0]  rem_sh, rem_n;
  logic [63:0]  q_n;
  logic         ov_n;
  logic [46:0]  thr;
  logic [45:0]  rm_n;
  logic signed [35:0] zr, zw, zf, cx_n, cy_n, cz_n, xs, ys, xo, yo, tt;
  logic         fneg;

  always_comb begin
    sa   = mag64(rd_a);
    sb   = mag64(rd_b);
    pa   = {rd_a[49:0], 14'd0};
    pmag = mag64(pa);

    mx = mcnt_q[1] ? ua_q[63:32] : ua_q[31:0];
    my = mcnt_q[0] ? ub_q[63:32] : ub_q[31:0];
    mp = mx * my;
    case (mcnt_q)
      2'd0:    addend = {64'd0, mp};
      2'd3:    addend = {mp, 64'd0};
      default: addend = {32'd0, mp, 32'd0};
    endcase
    mm = (acc_q[127:79] != 49'd0) ? SMAX : {1'b0, acc_q[78:16]};

    rem_sh = {rem_q[63:0], dvd_q[79]};
    ov_n   = ov_q | (quo_q[63:62] != 2'b00);
    if (rem_sh >= {1'b0, ub_q}) begin
      rem_n = rem_sh - {1'b0, ub_q};
      q_n   = {quo_q[62:0], 1'b1};
    end else begin
      rem_n = rem_sh;
      q_n   = {quo_q[62:0], 1'b0};
    end

    thr  = {11'd0, Q30_TWO_PI} << rk_q;
    rm_n = ({1'b0, rm_q} >= thr) ? (rm_q - thr[45:0]) : rm_q;
    zr   = aneg_q ? -$signed({3'd0, rm_n[32:0]}) : $signed({3'd0, rm_n[32:0]});
    if (zr >= $signed(Q30_PI)) zw = zr - $signed(Q30_TWO_PI);
    else if (zr < -$signed(Q30_PI)) zw = zr + $signed(Q30_TWO_PI);
    else zw = zr;
    fneg = 1'b0;
    zf   = zw;
    if (zw > $signed(Q30_HALF_PI)) begin
      zf = zw - $signed(Q30_PI); fneg = 1'b1;
    end else if (zw < -$signed(Q30_HALF_PI)) begin
      zf = zw + $signed(Q30_PI); fneg = 1'b1;
    end

    xs = cy_q >>> ci_q;
    ys = cx_q >>> ci_q;
    tt = $signed(cordic_atan(5'(ci_q)));
    if (cz_q >= 0) begin
      cx_n = cx_q - xs; cy_n = cy_q + ys; cz_n = cz_q - tt;
    end else begin
      cx_n = cx_q + xs; cy_n = cy_q - ys; cz_n = cz_q + tt;
    end
    xo = (cneg_q ? -cx_n : cx_n) >>> 14;
    yo = (cneg_q ? -cy_n : cy_n) >>> 14;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ust_q  <= U_IDLE;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (ust_q)
        U_IDLE: begin
          if (cmd_i.start) begin
            case (cmd_i.op)
              OP_ADD: begin
                res0_q <= sat_add({rd_a[63], rd_a} + {rd_b[63], rd_b});
                done_q <= 1'b1;
              end
              OP_SUB: begin
                res0_q <= sat_add({rd_a[63], rd_a} - {rd_b[63], rd_b});
                done_q <= 1'b1;
              end
              OP_SATADD: begin
                res0_q <= sat32x(sat_add({rd_a[63], rd_a} + {rd_b[63], rd_b}));
                done_q <= 1'b1;
              end
              OP_MUL: begin
                ust_q <= U_MUL;
              end
              OP_DIV: begin
                if (sa == 64'd0) begin
                  res0_q <= 64'd0;
                  done_q <= 1'b1;
                end else if (sb == 64'd0) begin
                  res0_q <= rd_a[63] ? NSMAX : SMAX;
                  done_q <= 1'b1;
                end else begin
                  ust_q <= U_DIV;
                end
              end
              OP_SINCOS: begin
                ust_q <= U_RED;
              end
              default: begin
                done_q <= 1'b1;
              end
            endcase
          end
        end
        U_MUL: begin
          if (mcnt_q == 2'd3) ust_q <= U_MFIN;
        end
        U_MFIN: begin
          res0_q <= signed_of(mm, neg_q);
          done_q <= 1'b1;
          ust_q  <= U_IDLE;
        end
        U_DIV: begin
          if (dcnt_q == 7'd79) begin
            res0_q <= signed_of(ov_n ? SMAX : q_n, neg_q);
            done_q <= 1'b1;
            ust_q  <= U_IDLE;
          end
        end
        U_RED: begin
          if (rk_q == 4'd0) ust_q <= U_ROT;
        end
        U_ROT: begin
          if (ci_q == IW'(CORDIC_ITERS - 1)) begin
            res0_q <= {{28{yo[35]}}, yo};
            res1_q <= {{28{xo[35]}}, xo};
            done_q <= 1'b1;
            ust_q  <= U_IDLE;
          end
        end
        default: ust_q <= U_IDLE;
      endcase
    end
  end

  // unit working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q   <= cmd_i.op;
      ua_q   <= sa;
      ub_q   <= sb;
      neg_q  <= rd_a[63] ^ rd_b[63];
      acc_q  <= 128'd0;
      mcnt_q <= 2'd0;
      dvd_q  <= {sa, 16'd0};
      rem_q  <= 65'd0;
      quo_q  <= 64'd0;
      ov_q   <= 1'b0;
      dcnt_q <= 7'd0;
      rm_q   <= pmag[45:0];
      aneg_q <= rd_a[63];
      rk_q   <= 4'd13;
    end else begin
      case (ust_q)
        U_MUL: begin
          acc_q  <= acc_q + addend;
          mcnt_q <= mcnt_q + 2'd1;
        end
        U_DIV: begin
          rem_q  <= rem_n;
          quo_q  <= q_n;
          ov_q   <= ov_n;
          dvd_q  <= {dvd_q[78:0], 1'b0};
          dcnt_q <= dcnt_q + 7'd1;
        end
        U_RED: begin
          rm_q <= rm_n;
          rk_q <= rk_q - 4'd1;
          if (rk_q == 4'd0) begin
            cx_q   <= $signed(Q30_GAIN);
            cy_q   <= 36'sd0;
            cz_q   <= zf;
            cneg_q <= fneg;
            ci_q   <= '0;
          end
        end
        U_ROT: begin
          cx_q <= cx_n;
          cy_q <= cy_n;
          cz_q <= cz_n;
          ci_q <= ci_q + IW'(1);
        end
        default: ;
      endcase
    end
  end

  // ---- output register ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_o <= {1'b0, in_q[6], in_q[5], st_q[4], st_q[3], st_q[2], st_q[1], st_q[0],
                     cmd_i.step};
      out_bad_o  <= cmd_i.bad;
      out_last_o <= cmd_i.last;
    end
  end

  assign sts_o.unit_done = done_q;
  assign sts_o.speed_bad = $signed(in_q[6]) <= 32'sd0;
  assign sts_o.out_free  = !out_valid_o || out_ready_i;

endmodule

### design/bmr_ctrl.sv
// ----------------------------------------------------------------------------
// bmr_ctrl
// Controller: takes an item, loads the register file, walks the step
// microprogram HORIZON times and hands each step's state to the output.
// ----------------------------------------------------------------------------
module bmr_ctrl #(
  parameter int HORIZON = bmr_pkg::HORIZON_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output bmr_pkg::cmd_t cmd_o,
  input  bmr_pkg::sts_t sts_i
);
  import bmr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_LOAD, S_ISSUE, S_START, S_WAIT, S_WR, S_WR2, S_EMIT
  } state_e;

  state_e     state_q;
  logic [5:0] pc_q;
  logic [4:0] lcnt_q;
  logic [6:0] step_q;
  logic       bad_q;
  uop_t       uop;
  logic       last_step;

  assign uop       = ucode(pc_q);
  assign last_step = bad_q || (step_q == 7'(HORIZON));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      lcnt_q  <= '0;
      step_q  <= '0;
      bad_q   <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_CHECK;
        end
        S_CHECK: begin
          step_q <= '0;
          lcnt_q <= '0;
          bad_q  <= sts_i.speed_bad;
          state_q <= sts_i.speed_bad ? S_EMIT : S_LOAD;
        end
        S_LOAD: begin
          lcnt_q <= lcnt_q + 5'd1;
          if (lcnt_q == R_ZERO) begin
            pc_q    <= '0;
            state_q <= S_ISSUE;
          end
        end
        S_ISSUE: state_q <= S_START;
        S_START: state_q <= S_WAIT;
        S_WAIT: begin
          if (sts_i.unit_done) state_q <= S_WR;
        end
        S_WR, S_WR2: begin
          if (state_q == S_WR && uop.op == OP_SINCOS) begin
            state_q <= S_WR2;
          end else if (pc_q == LAST_PC) begin
            step_q  <= step_q + 7'd1;
            state_q <= S_EMIT;
          end else begin
            pc_q    <= pc_q + 6'd1;
            state_q <= S_ISSUE;
          end
        end
        S_EMIT: begin
          if (sts_i.out_free) begin
            if (last_step) begin
              state_q <= S_IDLE;
            end else begin
              pc_q    <= STEP_START;
              state_q <= S_ISSUE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    in_ready_o      = (state_q == S_IDLE);
    cmd_o           = '0;
    cmd_o.op        = uop.op;
    cmd_o.rd_a      = uop.a;
    cmd_o.rd_b      = uop.b;
    cmd_o.ld_idx    = lcnt_q;
    cmd_o.step      = bad_q ? 7'd0 : step_q;
    cmd_o.bad       = bad_q;
    cmd_o.last      = last_step;
    cmd_o.wr_addr   = uop.dst;
    cmd_o.capture   = (state_q == S_IDLE) && in_valid_i;
    cmd_o.ld_we     = (state_q == S_LOAD);
    cmd_o.start     = (state_q == S_START);
    cmd_o.wr0       = (state_q == S_WR);
    cmd_o.wr1       = (state_q == S_WR2);
    if (state_q == S_WR2) cmd_o.wr_addr = uop.dst + 5'd1;
    cmd_o.emit      = (state_q == S_EMIT) && sts_i.out_free;
  end

endmodule

### design/bicycle_model_rollout.sv
// ----------------------------------------------------------------------------
// bicycle_model_rollout
// Forward-Euler rollout of a linear-tyre dynamic bicycle model.
// ----------------------------------------------------------------------------
// One transfer on the slave stream carries an initial vehicle state. The block
// integrates HORIZON Euler steps with steer and speed held and sends one
// master transfer per step: step index and predicted state in tdata, the
// abort flag in tuser, tlast on the final step. A speed that is not positive
// gives one transfer with step index 0, the input echoed, tuser and tlast set;
// the block is ready again in the same cycle that this transfer becomes valid.
// Items are worked one at a time; s_axis_tready is high only while idle.
// One step runs a 41-entry microprogram on shared units after a 2-entry setup:
// a four-pass 32x32 multiplier (16 products a step), a bit-serial divider
// (9 divisions a step) and a CORDIC unit (used twice a step). A division
// whose quotient is trivially zero or saturated skips the bit-serial pass.
// The output register holds a result until m_axis_tready; the next step stalls
// there while it is full. Reset clears the controller and the output valid and
// restores the register defaults; write configuration only while idle.
// ----------------------------------------------------------------------------
module bicycle_model_rollout #(
  parameter int HORIZON      = bmr_pkg::HORIZON_DEF,
  parameter int CORDIC_ITERS = bmr_pkg::CORDIC_ITERS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // slip_angle, heading, heading_rate, pos_x, pos_y, steer_angle, speed
  input  logic [223:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // step_index, pred_slip, pred_heading, pred_rate, pred_x, pred_y,
  // pred_steer, pred_speed, one zero pad bit
  output logic [231:0] m_axis_tdata,
  // bad_speed
  output logic         m_axis_tuser,
  output logic         m_axis_tlast
);
  import bmr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bmr_ctrl #(.HORIZON(HORIZON)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  bmr_dp #(.CORDIC_ITERS(CORDIC_ITERS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_bad_o   (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule
